[src/lsra_pkg.sv]
// Package for the line sensor run analyzer.
// Holds the scan record carried along the cell chain and the centring constants.
// No dependencies.
package lsra_pkg;

	localparam int unsigned POS_COUNT = 16;

	localparam logic [4:0] LAST_SPLIT_POS  = 5'd15;
	localparam logic [4:0] END_POS         = 5'd16;
	localparam logic [4:0] CENTER_MID      = 5'd8;
	localparam logic [4:0] TARGET_RESET    = 5'd8;
	localparam logic [4:0] WIDTH_CENTER_LO = 5'd6;
	localparam logic [4:0] WIDTH_CENTER_HI = 5'd14;
	localparam logic [4:0] WIDE_MIN        = 5'd12;

	typedef enum logic [1:0] {
		PH_SEARCH = 2'd0,
		PH_RUN    = 2'd1,
		PH_AFTER  = 2'd2
	} phase_t;

	typedef struct packed {
		logic [POS_COUNT-1:0] bits;
		phase_t               phase;
		logic [4:0]           start;
		logic [4:0]           stop;
		logic                 split;
	} scan_t;

endpackage

[src/lsra_cell.sv]
// One position cell of the run scan chain.
// Examines the leading bit of the word, updates the scan record and registers it.
// Depends on lsra_pkg.
module lsra_cell #(
	parameter logic [4:0] POS = 5'd1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  lsra_pkg::scan_t in_rec,
	output logic            out_valid,
	input  logic            out_ready,
	output lsra_pkg::scan_t out_rec
);
	import lsra_pkg::*;

	logic  valid_q;
	scan_t rec_q;
	scan_t rec_d;
	logic  bit_seen;

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_rec   = rec_q;
	assign bit_seen  = in_rec.bits[POS_COUNT-1];

	always_comb begin
		rec_d      = in_rec;
		rec_d.bits = {in_rec.bits[POS_COUNT-2:0], 1'b0};
		unique case (in_rec.phase)
			PH_SEARCH: begin
				if (bit_seen) begin
					rec_d.start = POS;
					rec_d.phase = PH_RUN;
				end
			end
			PH_RUN: begin
				if (!bit_seen) begin
					rec_d.stop  = POS;
					rec_d.phase = PH_AFTER;
				end
			end
			PH_AFTER: begin
				// A second run made only of the last position does not count.
				if (bit_seen && POS <= LAST_SPLIT_POS) begin
					rec_d.split = 1'b1;
				end
			end
			default: begin
				rec_d.phase = in_rec.phase;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			rec_q <= rec_d;
		end
	end

endmodule

[src/lsra_result.sv]
// Output stage of the run analyzer: width, centre, overrides and error.
// Keeps the wide-line flag of the previous beat and holds the result register.
// Depends on lsra_pkg.
module lsra_result (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [4:0]        target,
	input  logic              in_valid,
	output logic              in_ready,
	input  lsra_pkg::scan_t   in_rec,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [4:0]        center,
	output logic [4:0]        width,
	output logic              split_line,
	output logic              wide_line,
	output logic              prev_wide_line,
	output logic signed [5:0] position_error
);
	import lsra_pkg::*;

	logic              valid_q;
	logic              wide_q;
	logic [4:0]        center_q;
	logic [4:0]        width_q;
	logic              split_q;
	logic              wide_line_q;
	logic              prev_q;
	logic signed [5:0] error_q;

	logic [4:0] stop_eff;
	logic [4:0] span;
	logic [4:0] width_d;
	logic [4:0] center_d;
	logic       wide_d;
	logic       load;

	assign in_ready = !valid_q || out_ready;
	assign load     = in_valid && in_ready;

	always_comb begin
		// A run that is still open at the end of the chain reaches the last position.
		stop_eff = (in_rec.phase == PH_RUN) ? END_POS : in_rec.stop;
		span     = stop_eff - in_rec.start;
		width_d  = span + 5'd1;
		center_d = {1'b0, span[4:1]} + in_rec.start;
		wide_d   = width_d >= WIDE_MIN;
		if (target == CENTER_MID && width_d >= WIDTH_CENTER_LO
				&& width_d < WIDTH_CENTER_HI) begin
			center_d = CENTER_MID;
		end
		if (in_rec.split || wide_d) begin
			center_d = CENTER_MID;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			wide_q  <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_q <= in_valid;
			end
			if (load) begin
				wide_q <= wide_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			center_q    <= center_d;
			width_q     <= width_d;
			split_q     <= in_rec.split;
			wide_line_q <= wide_d;
			prev_q      <= wide_q;
			error_q     <= $signed({1'b0, center_d} - {1'b0, target});
		end
	end

	assign out_valid      = valid_q;
	assign center         = center_q;
	assign width          = width_q;
	assign split_line     = split_q;
	assign wide_line      = wide_line_q;
	assign prev_wide_line = prev_q;
	assign position_error = error_q;

`ifndef SYNTHESIS
	a_wide_forces_mid: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && wide_line_q |-> center_q == CENTER_MID)
		else $error("wide line did not force the middle centre");
	a_split_forces_mid: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && split_q |-> center_q == CENTER_MID)
		else $error("split line did not force the middle centre");
	a_flag_tracks_output: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> wide_q == wide_line_q)
		else $error("stored wide flag differs from the shown result");
	a_width_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> width_q != 5'd0 && width_q <= END_POS)
		else $error("width out of range");
`endif

endmodule

[src/line_sensor_run_analyzer.sv]
// Top level of the line sensor run analyzer: target register, cell chain, output stage.
// Depends on lsra_pkg, lsra_cell and lsra_result.
//
//  channel | signals                                 | beat when
//  --------+-----------------------------------------+----------------------
//  in      | in_valid, in_ready, sensor_bits         | in_valid && in_ready
//  out     | out_valid, out_ready, center, width,    | out_valid && out_ready
//          | split_line, wide_line, prev_wide_line,  |
//          | position_error                          |
//  cfg     | cfg_wen, cfg_wdata (target centre)      | cfg_wen
//
// One beat is accepted per cycle unless an output stall has backed up to the input;
// it passes through a register in each position cell, then the output register.
// Reset empties the chain, clears the wide-line flag and sets the target to 8.
// A stall at the output reaches back combinationally through the stages holding a beat;
// bubbles in the chain are squeezed out, so input keeps flowing until every stage holds a beat.
module line_sensor_run_analyzer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wen,
	input  logic [4:0]        cfg_wdata,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [15:0]       sensor_bits,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [4:0]        center,
	output logic [4:0]        width,
	output logic              split_line,
	output logic              wide_line,
	output logic              prev_wide_line,
	output logic signed [5:0] position_error
);
	import lsra_pkg::*;

	logic [4:0]         target_q;
	scan_t              chain_rec   [0:POS_COUNT];
	logic [POS_COUNT:0] chain_valid;
	logic [POS_COUNT:0] chain_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= TARGET_RESET;
		end else if (cfg_wen) begin
			target_q <= cfg_wdata;
		end
	end

	assign chain_rec[0] = '{bits: sensor_bits, phase: PH_SEARCH, start: 5'd0, stop: 5'd0,
		split: 1'b0};

	assign chain_valid[0] = in_valid;
	assign in_ready       = chain_ready[0];

	for (genvar i = 0; i < POS_COUNT; i++) begin : g_cell
		lsra_cell #(
			.POS(5'(i + 1))
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (chain_valid[i]),
			.in_ready (chain_ready[i]),
			.in_rec   (chain_rec[i]),
			.out_valid(chain_valid[i+1]),
			.out_ready(chain_ready[i+1]),
			.out_rec  (chain_rec[i+1])
		);
	end

	lsra_result u_result (
		.clk           (clk),
		.arst_n        (arst_n),
		.target        (target_q),
		.in_valid      (chain_valid[POS_COUNT]),
		.in_ready      (chain_ready[POS_COUNT]),
		.in_rec        (chain_rec[POS_COUNT]),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.center        (center),
		.width         (width),
		.split_line    (split_line),
		.wide_line     (wide_line),
		.prev_wide_line(prev_wide_line),
		.position_error(position_error)
	);

endmodule
